// File: rtl/core/tscc_pkg.sv
`timescale 1ns / 1ps

package tscc_pkg;

   // defaults for the top level parameters
   localparam int LINE_MAX_DEF    = 32;
   localparam int FLASH_COUNT_DEF = 2;

   // period register values after reset
   localparam logic [15:0] TURN_PERIOD_RST   = 16'd400;
   localparam logic [15:0] UTURN_PERIOD_RST  = 16'd200;
   localparam logic [15:0] ARRIVE_PERIOD_RST = 16'd500;
   localparam logic [15:0] FLASH_PERIOD_RST  = 16'd100;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;

   typedef enum logic [2:0] {
      SIG_OFF    = 3'd0,
      SIG_LEFT   = 3'd1,
      SIG_RIGHT  = 3'd2,
      SIG_UTURN  = 3'd3,
      SIG_ARRIVE = 3'd4,
      SIG_FLASH  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_ACCEPT  = 2'd1,
      EV_UNKNOWN = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CSR_TURN_PERIOD   = 2'd0,
      CSR_UTURN_PERIOD  = 2'd1,
      CSR_ARRIVE_PERIOD = 2'd2,
      CSR_FLASH_PERIOD  = 2'd3
   } csr_index_type;

   // result of a finished line, handed from the parser to the sequencer
   typedef struct packed {
      event_type event_res;
      mode_type  mode;
   } cmd_type;

   // keyword table
   localparam int KW_COUNT   = 6;
   localparam int KW_LEN_MAX = 8;
   localparam int KW_POS_W   = 4;
   localparam logic [KW_POS_W-1:0] KW_POS_SAT = KW_POS_W'(KW_LEN_MAX + 1);

   typedef logic [0:KW_LEN_MAX-1][7:0] kw_text_type;

   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      '{"L", "E", "F", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "I", "G", "H", "T", 8'h00, 8'h00, 8'h00},
      '{"U", "T", "U", "R", "N", 8'h00, 8'h00, 8'h00},
      '{"A", "R", "R", "I", "V", "E", 8'h00, 8'h00},
      '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "T", "R", "A", "I", "G", "H", "T"}
   };

   localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd5, 4'd5, 4'd6, 4'd4, 4'd8
   };

   // stop selects off
   localparam mode_type KW_MODE [KW_COUNT] = '{
      SIG_LEFT, SIG_RIGHT, SIG_UTURN, SIG_ARRIVE, SIG_OFF, SIG_FLASH
   };

endpackage

// File: rtl/core/tscc_line_parser.sv
`timescale 1ns / 1ps

module tscc_line_parser #(
   parameter int LINE_MAX = tscc_pkg::LINE_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_en,
   input  logic [7:0]       rx_byte,
   output tscc_pkg::cmd_type cmd
);
   import tscc_pkg::*;

   localparam int LEN_W = $clog2(LINE_MAX + 1);

   logic [LEN_W-1:0]    len_ff, len_in;
   logic                started_ff, started_in;
   logic                gap_ff, gap_in;
   logic [KW_POS_W-1:0] pos_ff, pos_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;

   logic is_term;
   logic is_blank;
   logic any_hit;
   mode_type hit_mode;

   assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
   assign is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                     (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);

   // keyword that the trimmed line equals, if any
   always_comb begin
      any_hit  = 1'b0;
      hit_mode = SIG_OFF;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (alive_ff[k] && (pos_ff == KW_LEN[k])) begin
            any_hit  = 1'b1;
            hit_mode = KW_MODE[k];
         end
      end
   end

   always_comb begin
      cmd.mode = hit_mode;
      if (!started_ff) begin
         cmd.event_res = EV_NONE;
      end else if (any_hit) begin
         cmd.event_res = EV_ACCEPT;
      end else begin
         cmd.event_res = EV_UNKNOWN;
      end
   end

   always_comb begin
      len_in     = len_ff;
      started_in = started_ff;
      gap_in     = gap_ff;
      pos_in     = pos_ff;
      alive_in   = alive_ff;
      if (byte_en) begin
         if (is_term || (len_ff >= LEN_W'(LINE_MAX))) begin
            // line finished or overflowed: start over empty
            len_in     = '0;
            started_in = 1'b0;
            gap_in     = 1'b0;
            pos_in     = '0;
            alive_in   = '1;
         end else begin
            len_in = len_ff + LEN_W'(1);
            if (is_blank) begin
               if (started_ff) begin
                  gap_in = 1'b1;
               end
            end else begin
               started_in = 1'b1;
               // a blank between characters rules out every keyword
               if (gap_ff) begin
                  alive_in = '0;
               end else begin
                  for (int k = 0; k < KW_COUNT; k++) begin
                     alive_in[k] = alive_ff[k] && (pos_ff < KW_LEN[k]) &&
                                   (KW_TEXT[k][pos_ff[2:0]] == rx_byte);
                  end
               end
               if (pos_ff != KW_POS_SAT) begin
                  pos_in = pos_ff + KW_POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         started_ff <= 1'b0;
         gap_ff     <= 1'b0;
         pos_ff     <= '0;
         alive_ff   <= '1;
      end else begin
         len_ff     <= len_in;
         started_ff <= started_in;
         gap_ff     <= gap_in;
         pos_ff     <= pos_in;
         alive_ff   <= alive_in;
      end
   end

endmodule

// File: rtl/core/tscc_lamp_sequencer.sv
`timescale 1ns / 1ps

module tscc_lamp_sequencer #(
   parameter int FLASH_COUNT = tscc_pkg::FLASH_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  logic               cmd_en,
   input  tscc_pkg::cmd_type  cmd,
   input  logic [15:0]        turn_period,
   input  logic [15:0]        uturn_period,
   input  logic [15:0]        arrive_period,
   input  logic [15:0]        flash_period,
   output logic               lamp_left,
   output logic               lamp_right,
   output tscc_pkg::mode_type mode_now
);
   import tscc_pkg::*;

   localparam logic [3:0] FLASH_HALVES = 4'(2 * FLASH_COUNT);

   mode_type    mode_ff, mode_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        phase_ff, phase_in;
   logic        side_ff, side_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  lamp_ff, lamp_in;

   logic [15:0] period;
   logic        active;
   logic [15:0] elapsed_inc;
   logic        fire;
   logic [3:0]  step_next;

   always_comb begin
      active = 1'b1;
      unique case (mode_ff)
         SIG_LEFT, SIG_RIGHT: period = turn_period;
         SIG_UTURN:           period = uturn_period;
         SIG_ARRIVE:          period = arrive_period;
         SIG_FLASH:           period = flash_period;
         default: begin
            period = '0;
            active = 1'b0;
         end
      endcase
   end

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign fire        = (elapsed_inc >= period);
   assign step_next   = {1'b0, step_ff} + 4'd1;

   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      side_in    = side_ff;
      step_in    = step_ff;
      lamp_in    = lamp_ff;
      if (cmd_en) begin
         mode_in    = cmd.mode;
         elapsed_in = '0;
         phase_in   = 1'b0;
         side_in    = 1'b1;
         step_in    = '0;
         lamp_in    = (cmd.mode == SIG_FLASH) ? 2'b11 : 2'b00;
      end else if (tick_en && active) begin
         if (!fire) begin
            elapsed_in = elapsed_inc;
         end else begin
            elapsed_in = '0;
            unique case (mode_ff)
               SIG_LEFT: begin
                  phase_in = ~phase_ff;
                  lamp_in  = {1'b0, ~phase_ff};
               end
               SIG_RIGHT: begin
                  phase_in = ~phase_ff;
                  lamp_in  = {~phase_ff, 1'b0};
               end
               SIG_UTURN: begin
                  side_in = ~side_ff;
                  lamp_in = side_ff ? 2'b10 : 2'b01;
               end
               SIG_ARRIVE: begin
                  phase_in = ~phase_ff;
                  lamp_in  = {2{~phase_ff}};
               end
               default: begin
                  // straight flash: odd steps dark, done after all halves
                  if (step_next >= FLASH_HALVES) begin
                     mode_in  = SIG_OFF;
                     phase_in = 1'b0;
                     side_in  = 1'b1;
                     step_in  = '0;
                     lamp_in  = 2'b00;
                  end else begin
                     step_in = step_next[2:0];
                     lamp_in = step_next[0] ? 2'b00 : 2'b11;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= SIG_OFF;
         elapsed_ff <= '0;
         phase_ff   <= 1'b0;
         side_ff    <= 1'b1;
         step_ff    <= '0;
         lamp_ff    <= 2'b00;
      end else begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         side_ff    <= side_in;
         step_ff    <= step_in;
         lamp_ff    <= lamp_in;
      end
   end

   assign lamp_left  = lamp_ff[0];
   assign lamp_right = lamp_ff[1];
   assign mode_now   = mode_ff;

endmodule

// File: rtl/core/turn_signal_command_controller.sv
`timescale 1ns / 1ps

// Turn-signal command controller. Each request transaction is either a
// one-millisecond tick (req_operation 0) or a received character (req_operation 1),
// and each one yields exactly one response transaction with the lamp drive, the
// current mode and an event code (accepted command or unknown line on CR or LF).
// Lines of up to LINE_MAX characters are trimmed of blanks and matched against
// LEFT, RIGHT, UTURN, ARRIVE, STOP and STRAIGHT as the characters arrive, so no
// line buffer is kept. A request is registered, then processed into the mode and
// lamp state and the response register: one transaction per cycle is sustained
// while the response is not stalled. Period registers are written over the csr port,
// which is always ready and should only be used while no transaction is in flight.
module turn_signal_command_controller #(
   parameter int LINE_MAX    = tscc_pkg::LINE_MAX_DEF,
   parameter int FLASH_COUNT = tscc_pkg::FLASH_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_lamp_left,
   output logic                    rsp_lamp_right,
   output logic [2:0]              rsp_mode_now,
   output logic [1:0]              rsp_event_res,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tscc_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_data
);
   import tscc_pkg::*;

   logic [15:0] turn_period_ff;
   logic [15:0] uturn_period_ff;
   logic [15:0] arrive_period_ff;
   logic [15:0] flash_period_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_byte_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff;

   logic     advance;
   logic     req_take;
   cmd_type  cmd;
   mode_type mode_now;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_period_ff   <= TURN_PERIOD_RST;
         uturn_period_ff  <= UTURN_PERIOD_RST;
         arrive_period_ff <= ARRIVE_PERIOD_RST;
         flash_period_ff  <= FLASH_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TURN_PERIOD:   turn_period_ff   <= csr_data;
            CSR_UTURN_PERIOD:  uturn_period_ff  <= csr_data;
            CSR_ARRIVE_PERIOD: arrive_period_ff <= csr_data;
            CSR_FLASH_PERIOD:  flash_period_ff  <= csr_data;
         endcase
      end
   end

   // registered request moves on once the response register is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_operation;
         s1_byte_ff <= req_rx_byte;
      end
   end

   tscc_line_parser #(
      .LINE_MAX (LINE_MAX)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_en (advance && s1_op_ff),
      .rx_byte (s1_byte_ff),
      .cmd     (cmd)
   );

   // event is only reported for a character that ends a line
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s1_op_ff && ((s1_byte_ff == CHAR_LF) || (s1_byte_ff == CHAR_CR))) begin
            rsp_event_ff <= cmd.event_res;
         end else begin
            rsp_event_ff <= EV_NONE;
         end
      end
   end

   tscc_lamp_sequencer #(
      .FLASH_COUNT (FLASH_COUNT)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .tick_en       (advance && !s1_op_ff),
      .cmd_en        (advance && s1_op_ff && (cmd.event_res == EV_ACCEPT) &&
                      ((s1_byte_ff == CHAR_LF) || (s1_byte_ff == CHAR_CR))),
      .cmd           (cmd),
      .turn_period   (turn_period_ff),
      .uturn_period  (uturn_period_ff),
      .arrive_period (arrive_period_ff),
      .flash_period  (flash_period_ff),
      .lamp_left     (rsp_lamp_left),
      .lamp_right    (rsp_lamp_right),
      .mode_now      (mode_now)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mode_now  = mode_now;
   assign rsp_event_res = rsp_event_ff;

endmodule
